// ----- sv/fau_pkg.sv -----
// Types and constants shared by the fraction arithmetic unit modules.
package fau_pkg;

   localparam int NUM_WIDTH  = 33;
   localparam int DEN_WIDTH  = 31;
   localparam int STAT_WIDTH = 2;
   localparam int CMD_WIDTH  = 3;

   localparam logic [CMD_WIDTH-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_SUB    = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_MUL    = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_DIV    = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_REDUCE = 3'd4;

   localparam logic [STAT_WIDTH-1:0] STAT_OK          = 2'd0;
   localparam logic [STAT_WIDTH-1:0] STAT_ZERO_IN     = 2'd1;
   localparam logic [STAT_WIDTH-1:0] STAT_ZERO_RESULT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GCD,
      ST_SCALE,
      ST_DIV_A,
      ST_DIV_MID,
      ST_DIV_B,
      ST_MUL_1,
      ST_MUL_2,
      ST_MUL_3,
      ST_MUL_4,
      ST_REDUCE_OUT,
      ST_DONE
   } fau_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_CHECK,
      OP_GCD_STEP,
      OP_SCALE,
      OP_DIV_INIT2,
      OP_DIV_STEP,
      OP_MUL
   } fau_op_type;

   typedef enum logic [2:0] {
      MS_AN_QB,
      MS_BN_QA,
      MS_QA_BD,
      MS_AN_BN,
      MS_AD_BD,
      MS_AN_BD,
      MS_AD_BNMAG
   } fau_mul_sel_type;

   typedef enum logic [2:0] {
      NS_HOLD,
      NS_ZERO,
      NS_ADD,
      NS_SUB,
      NS_PROD,
      NS_PROD_SIGNED,
      NS_REDUCE
   } fau_num_sel_type;

   typedef enum logic [1:0] {
      DS_HOLD,
      DS_ZERO,
      DS_PROD,
      DS_QA
   } fau_den_sel_type;

   typedef struct packed {
      fau_op_type      op;
      fau_mul_sel_type mul_sel;
      fau_num_sel_type num_sel;
      fau_den_sel_type den_sel;
   } fau_cmd_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] command;
      logic                 zero_in;
      logic                 gcd_done;
      logic                 div_done;
   } fau_flags_type;

endpackage

// ----- sv/fau_ctrl.sv -----
// Sequencing state machine of the fraction arithmetic unit.
module fau_ctrl
   import fau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  fau_flags_type flags,
   output fau_cmd_type   cmd,
   output logic          busy,
   output logic          rsp_valid
);

   fau_state_type state_ff, state_in;
   logic          valid_ff, valid_in;
   logic          is_addsub;

   assign is_addsub = (flags.command == CMD_ADD) || (flags.command == CMD_SUB);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      valid_in    = 1'b0;
      cmd.op      = OP_NONE;
      cmd.mul_sel = MS_AN_BN;
      cmd.num_sel = NS_HOLD;
      cmd.den_sel = DS_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // The check also loads the GCD operands and clears the result.
            cmd.op      = OP_CHECK;
            cmd.num_sel = NS_ZERO;
            cmd.den_sel = DS_ZERO;
            priority if (flags.zero_in) begin
               state_in = ST_DONE;
            end else if (flags.command == CMD_MUL || flags.command == CMD_DIV) begin
               state_in = ST_MUL_1;
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (flags.gcd_done) begin
               state_in = ST_SCALE;
            end else begin
               cmd.op = OP_GCD_STEP;
            end
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = ST_DIV_A;
         end
         ST_DIV_A: begin
            cmd.op = OP_DIV_STEP;
            if (flags.div_done) begin
               state_in = ST_DIV_MID;
            end
         end
         ST_DIV_MID: begin
            cmd.op   = OP_DIV_INIT2;
            state_in = ST_DIV_B;
         end
         ST_DIV_B: begin
            cmd.op = OP_DIV_STEP;
            if (flags.div_done) begin
               state_in = is_addsub ? ST_MUL_1 : ST_REDUCE_OUT;
            end
         end
         ST_MUL_1: begin
            cmd.op = OP_MUL;
            priority if (is_addsub) begin
               cmd.mul_sel = MS_AN_QB;
            end else if (flags.command == CMD_MUL) begin
               cmd.mul_sel = MS_AN_BN;
            end else begin
               cmd.mul_sel = MS_AN_BD;
            end
            state_in = ST_MUL_2;
         end
         ST_MUL_2: begin
            cmd.op = OP_MUL;
            priority if (is_addsub) begin
               cmd.mul_sel = MS_BN_QA;
            end else if (flags.command == CMD_MUL) begin
               cmd.mul_sel = MS_AD_BD;
               cmd.num_sel = NS_PROD;
            end else begin
               cmd.mul_sel = MS_AD_BNMAG;
               cmd.num_sel = NS_PROD_SIGNED;
            end
            state_in = ST_MUL_3;
         end
         ST_MUL_3: begin
            if (is_addsub) begin
               cmd.op      = OP_MUL;
               cmd.mul_sel = MS_QA_BD;
               cmd.num_sel = (flags.command == CMD_SUB) ? NS_SUB : NS_ADD;
               state_in    = ST_MUL_4;
            end else begin
               cmd.den_sel = DS_PROD;
               state_in    = ST_DONE;
            end
         end
         ST_MUL_4: begin
            cmd.den_sel = DS_PROD;
            state_in    = ST_DONE;
         end
         ST_REDUCE_OUT: begin
            cmd.num_sel = NS_REDUCE;
            cmd.den_sel = DS_QA;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not make the unit busy");

   a_valid_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(state_ff) == ST_DONE))
      else $error("result strobe outside the completion cycle");

   a_gcd_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD && flags.gcd_done) |=> state_ff == ST_SCALE)
      else $error("GCD loop did not stop on completion");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_A && flags.div_done) |=> state_ff == ST_DIV_MID)
      else $error("first division did not stop after its last step");

endmodule

// ----- sv/fau_datapath.sv -----
// Operand registers, binary GCD, restoring divider and multiplier of the fraction unit.
module fau_datapath
   import fau_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
)
(
   input  logic                               clock,
   input  logic [CMD_WIDTH-1:0]               req_command,
   input  logic signed [OPERAND_WIDTH-1:0]    req_a_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]    req_a_denominator,
   input  logic signed [OPERAND_WIDTH-1:0]    req_b_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]    req_b_denominator,
   input  fau_cmd_type                        cmd,
   output fau_flags_type                      flags,
   output logic signed [NUM_WIDTH-1:0]        rsp_result_numerator,
   output logic [DEN_WIDTH-1:0]               rsp_result_denominator,
   output logic [STAT_WIDTH-1:0]              rsp_status
);

   localparam int W  = OPERAND_WIDTH;
   localparam int KW = $clog2(OPERAND_WIDTH);

   // Normalised operands: denominators as magnitudes, signs in the numerators.
   logic [CMD_WIDTH-1:0]       cmd_ff, cmd_in;
   logic signed [W:0]          an_ff, an_in, bn_ff, bn_in;
   logic [W-1:0]               ad_ff, ad_in, bd_ff, bd_in;
   logic                       zin_ff, zin_in;

   logic [W-1:0]               u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [KW-1:0]              k_ff, k_in;

   logic [W-1:0]               rem_ff, rem_in, quo_ff, quo_in, qa_ff, qa_in;
   logic [KW-1:0]              dcnt_ff, dcnt_in;

   logic signed [NUM_WIDTH-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [NUM_WIDTH-1:0] num_ff, num_in;
   logic [DEN_WIDTH-1:0]        den_ff, den_in;
   logic [STAT_WIDTH-1:0]       stat_ff, stat_in;

   logic signed [W:0]          an_ext, bn_ext, an_neg_full, bn_neg_full;
   logic [W-1:0]               an_mag, bn_mag;
   logic                       addsub;
   logic                       gcd_done;
   logic [W:0]                 shifted, diff;
   logic                       fits;
   logic signed [NUM_WIDTH-1:0] mul_a, mul_b;
   logic [NUM_WIDTH-1:0]       q_ext;

   assign addsub   = (cmd_ff == CMD_ADD) || (cmd_ff == CMD_SUB);
   assign gcd_done = (u_ff == '0) || (v_ff == '0);

   assign an_ext = {req_a_numerator[W-1], req_a_numerator};
   assign bn_ext = {req_b_numerator[W-1], req_b_numerator};

   assign an_neg_full = -an_ff;
   assign bn_neg_full = -bn_ff;
   assign an_mag      = an_ff[W] ? an_neg_full[W-1:0] : an_ff[W-1:0];
   assign bn_mag      = bn_ff[W] ? bn_neg_full[W-1:0] : bn_ff[W-1:0];

   // One restoring division step.
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign fits    = (shifted >= {1'b0, g_ff});
   assign diff    = shifted - {1'b0, g_ff};

   assign q_ext = NUM_WIDTH'(quo_ff);

   assign flags.command  = cmd_ff;
   assign flags.zero_in  = zin_ff;
   assign flags.gcd_done = gcd_done;
   assign flags.div_done = (dcnt_ff == '0);

   assign rsp_result_numerator   = num_ff;
   assign rsp_result_denominator = den_ff;
   assign rsp_status             = stat_ff;

   always_comb begin
      unique case (cmd.mul_sel)
         MS_AN_QB: begin
            mul_a = NUM_WIDTH'(an_ff);
            mul_b = NUM_WIDTH'(quo_ff);
         end
         MS_BN_QA: begin
            mul_a = NUM_WIDTH'(bn_ff);
            mul_b = NUM_WIDTH'(qa_ff);
         end
         MS_QA_BD: begin
            mul_a = NUM_WIDTH'(qa_ff);
            mul_b = NUM_WIDTH'(bd_ff);
         end
         MS_AN_BN: begin
            mul_a = NUM_WIDTH'(an_ff);
            mul_b = NUM_WIDTH'(bn_ff);
         end
         MS_AD_BD: begin
            mul_a = NUM_WIDTH'(ad_ff);
            mul_b = NUM_WIDTH'(bd_ff);
         end
         MS_AN_BD: begin
            mul_a = NUM_WIDTH'(an_ff);
            mul_b = NUM_WIDTH'(bd_ff);
         end
         MS_AD_BNMAG: begin
            mul_a = NUM_WIDTH'(ad_ff);
            mul_b = NUM_WIDTH'(bn_mag);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      cmd_in  = cmd_ff;
      an_in   = an_ff;
      ad_in   = ad_ff;
      bn_in   = bn_ff;
      bd_in   = bd_ff;
      zin_in  = zin_ff;
      u_in    = u_ff;
      v_in    = v_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      qa_in   = qa_ff;
      dcnt_in = dcnt_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      stat_in = stat_ff;

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            cmd_in = req_command;
            an_in  = req_a_denominator[W-1] ? -an_ext : an_ext;
            ad_in  = req_a_denominator[W-1] ? -req_a_denominator : req_a_denominator;
            bn_in  = req_b_denominator[W-1] ? -bn_ext : bn_ext;
            bd_in  = req_b_denominator[W-1] ? -req_b_denominator : req_b_denominator;
            zin_in = (req_a_denominator == '0)
                     || ((req_command <= CMD_DIV) && (req_b_denominator == '0));
         end
         OP_CHECK: begin
            priority if (zin_ff) begin
               stat_in = STAT_ZERO_IN;
            end else if (cmd_ff == CMD_DIV && bn_ff == '0) begin
               stat_in = STAT_ZERO_RESULT;
            end else begin
               stat_in = STAT_OK;
            end
            u_in = addsub ? ad_ff : an_mag;
            v_in = addsub ? bd_ff : ad_ff;
            k_in = '0;
         end
         OP_GCD_STEP: begin
            // Binary GCD: common factors of two are counted in k and restored later.
            priority if (gcd_done) begin
               u_in = u_ff;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = (u_ff - v_ff) >> 1;
            end else begin
               v_in = (v_ff - u_ff) >> 1;
            end
         end
         OP_SCALE: begin
            g_in    = W'((u_ff | v_ff) << k_ff);
            quo_in  = ad_ff;
            rem_in  = '0;
            dcnt_in = KW'(W - 1);
         end
         OP_DIV_INIT2: begin
            qa_in   = quo_ff;
            quo_in  = addsub ? bd_ff : an_mag;
            rem_in  = '0;
            dcnt_in = KW'(W - 1);
         end
         OP_DIV_STEP: begin
            rem_in  = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_in  = {quo_ff[W-2:0], fits};
            dcnt_in = dcnt_ff - 1'b1;
         end
         OP_MUL: begin
            prod_in = mul_a * mul_b;
            acc_in  = prod_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (cmd.num_sel)
         NS_HOLD:        num_in = num_ff;
         NS_ZERO:        num_in = '0;
         NS_ADD:         num_in = acc_ff + prod_ff;
         NS_SUB:         num_in = acc_ff - prod_ff;
         NS_PROD:        num_in = prod_ff;
         NS_PROD_SIGNED: num_in = bn_ff[W] ? -prod_ff : prod_ff;
         NS_REDUCE:      num_in = an_ff[W] ? -q_ext : q_ext;
         default:        num_in = num_ff;
      endcase
      unique case (cmd.den_sel)
         DS_HOLD: den_in = den_ff;
         DS_ZERO: den_in = '0;
         DS_PROD: den_in = DEN_WIDTH'(prod_ff);
         DS_QA:   den_in = DEN_WIDTH'(qa_ff);
         default: den_in = den_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      zin_ff  <= zin_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      k_ff    <= k_in;
      g_ff    <= g_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      qa_ff   <= qa_in;
      dcnt_ff <= dcnt_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      stat_ff <= stat_in;
   end

endmodule

// ----- sv/fraction_arithmetic_unit.sv -----
// The duration of add, subtract and reduce is set by the binary GCD loop and two bit-serial
// divisions; multiply and divide skip both and go through the single shared multiplier.
// Throughput: one transfer at a time; start is taken again in the cycle the result appears.
// Reset is synchronous and active high; it returns the sequencer to idle and drops the strobe.
// The result is shown for exactly one cycle on rsp_valid and cannot be stalled by the receiver.
module fraction_arithmetic_unit
   import fau_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
)
(
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [CMD_WIDTH-1:0]               req_command,
   input  logic signed [OPERAND_WIDTH-1:0]    req_a_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]    req_a_denominator,
   input  logic signed [OPERAND_WIDTH-1:0]    req_b_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]    req_b_denominator,
   output logic                               rsp_valid,
   output logic signed [NUM_WIDTH-1:0]        rsp_result_numerator,
   output logic [DEN_WIDTH-1:0]               rsp_result_denominator,
   output logic [STAT_WIDTH-1:0]              rsp_status
);

   fau_cmd_type   cmd;
   fau_flags_type flags;

   fau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .flags     (flags),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   fau_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock                  (clock),
      .req_command            (req_command),
      .req_a_numerator        (req_a_numerator),
      .req_a_denominator      (req_a_denominator),
      .req_b_numerator        (req_b_numerator),
      .req_b_denominator      (req_b_denominator),
      .cmd                    (cmd),
      .flags                  (flags),
      .rsp_result_numerator   (rsp_result_numerator),
      .rsp_result_denominator (rsp_result_denominator),
      .rsp_status             (rsp_status)
   );

endmodule

// ----- test/tb_fraction_arithmetic_unit.sv -----
// Self-checking testbench for the fraction arithmetic unit: directed table, then random transfers.
`timescale 1ns / 100ps

module tb_fraction_arithmetic_unit
   import fau_pkg::*;
();

   localparam int OPERAND_WIDTH = 16;
   localparam int SETTLE_CYCLES = 80;

   // Commands 5 to 7 are reserved and behave as reduce.
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_7 = 3'd7;

   typedef logic signed [OPERAND_WIDTH-1:0] operand_type;

   typedef struct packed {
      logic signed [NUM_WIDTH-1:0] numerator;
      logic [DEN_WIDTH-1:0]        denominator;
      logic [STAT_WIDTH-1:0]       status;
   } fraction_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] command;
      operand_type          a_num;
      operand_type          a_den;
      operand_type          b_num;
      operand_type          b_den;
      logic                 typed;
      fraction_type         answer;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [CMD_WIDTH-1:0] req_command;
   operand_type req_a_numerator;
   operand_type req_a_denominator;
   operand_type req_b_numerator;
   operand_type req_b_denominator;
   logic rsp_valid;
   logic signed [NUM_WIDTH-1:0] rsp_result_numerator;
   logic [DEN_WIDTH-1:0] rsp_result_denominator;
   logic [STAT_WIDTH-1:0] rsp_status;

   fraction_type pending_fractions[$];
   stimulus_row_type directed_rows[$];
   int mismatches = 0;
   int sender_idle_pct = 0;

   fraction_arithmetic_unit #(.OPERAND_WIDTH(OPERAND_WIDTH)) i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_command            (req_command),
      .req_a_numerator        (req_a_numerator),
      .req_a_denominator      (req_a_denominator),
      .req_b_numerator        (req_b_numerator),
      .req_b_denominator      (req_b_denominator),
      .rsp_valid              (rsp_valid),
      .rsp_result_numerator   (rsp_result_numerator),
      .rsp_result_denominator (rsp_result_denominator),
      .rsp_status             (rsp_status)
   );

   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("fraction_arithmetic_unit test failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 100) begin
         $display("mismatch at %0t: %s", $time, what);
      end
   endtask

   function automatic bit [63:0] euclid_gcd(input bit [63:0] x, input bit [63:0] y);
      bit [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // All intermediate arithmetic wraps at 64 bits before being cut to the output widths.
   function automatic fraction_type predict_fraction(input logic [CMD_WIDTH-1:0] cmd,
                                                     input operand_type an, input operand_type ad,
                                                     input operand_type bn, input operand_type bd);
      longint sa, sad, sb, sbd;
      bit [63:0] anu, adu, bnu, bdu, g, x, y, num, den, mag, q;
      bit pair;
      fraction_type r;
      r = '0;
      pair = (cmd <= CMD_DIV);
      if (ad == 0 || (pair && bd == 0)) begin
         r.status = STAT_ZERO_IN;
         return r;
      end
      sa = an;
      sad = ad;
      sb = bn;
      sbd = bd;
      anu = sa;
      bnu = sb;
      adu = (sad < 0) ? -sad : sad;
      bdu = (sbd < 0) ? -sbd : sbd;
      if (sad < 0) anu = -anu;
      if (sbd < 0) bnu = -bnu;
      r.status = STAT_OK;
      if (cmd == CMD_ADD || cmd == CMD_SUB) begin
         g = euclid_gcd(adu, bdu);
         x = anu * (bdu / g);
         y = bnu * (adu / g);
         num = (cmd == CMD_ADD) ? x + y : x - y;
         den = (adu / g) * bdu;
      end else if (cmd == CMD_MUL) begin
         num = anu * bnu;
         den = adu * bdu;
      end else if (cmd == CMD_DIV) begin
         num = anu * bdu;
         den = adu * bnu;
         if (bnu == 0) begin
            den = 0;
            r.status = STAT_ZERO_RESULT;
         end else if (bnu[63]) begin
            num = -num;
            den = -den;
         end
      end else begin
         mag = anu[63] ? -anu : anu;
         g = euclid_gcd(mag, adu);
         q = mag / g;
         num = anu[63] ? -q : q;
         den = adu / g;
      end
      r.numerator = num[NUM_WIDTH-1:0];
      r.denominator = den[DEN_WIDTH-1:0];
      return r;
   endfunction

   task automatic add_row(input logic [CMD_WIDTH-1:0] cmd, input int an, input int ad,
                          input int bn, input int bd, input bit typed,
                          input longint num, input longint den, input logic [STAT_WIDTH-1:0] st);
      stimulus_row_type row;
      row.command = cmd;
      row.a_num = operand_type'(an);
      row.a_den = operand_type'(ad);
      row.b_num = operand_type'(bn);
      row.b_den = operand_type'(bd);
      row.typed = typed;
      row.answer.numerator = num[NUM_WIDTH-1:0];
      row.answer.denominator = den[DEN_WIDTH-1:0];
      row.answer.status = st;
      directed_rows.push_back(row);
   endtask

   // Holds start high with the item until a transfer happens, with random gaps in front.
   task automatic issue_fraction(input logic [CMD_WIDTH-1:0] cmd,
                                 input operand_type an, input operand_type ad,
                                 input operand_type bn, input operand_type bd,
                                 input fraction_type answer);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_a_numerator <= an;
      req_a_denominator <= ad;
      req_b_numerator <= bn;
      req_b_denominator <= bd;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_fractions.push_back(answer);
   endtask

   function automatic operand_type random_field();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) return operand_type'(int'($urandom_range(24)) - 12);
      if (pick < 75) return operand_type'($urandom);
      if (pick < 90) begin
         case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'hffff;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'h7fff;
         endcase
      end
      if ($urandom_range(1) == 0) return operand_type'(1 << $urandom_range(14));
      return operand_type'(-(1 << $urandom_range(15)));
   endfunction

   function automatic operand_type random_denominator();
      operand_type d;
      d = random_field();
      if ($urandom_range(99) < 4) return '0;
      if (d == 0) return operand_type'(1);
      return d;
   endfunction

   always @(posedge clock) begin : check_results
      fraction_type want;
      if (!reset && rsp_valid) begin
         if (pending_fractions.size() == 0) begin
            report_mismatch("result with no transfer pending");
         end else begin
            want = pending_fractions.pop_front();
            if (rsp_result_numerator !== want.numerator) begin
               report_mismatch($sformatf("numerator %0d, expected %0d",
                                         rsp_result_numerator, want.numerator));
            end
            if (rsp_result_denominator !== want.denominator) begin
               report_mismatch($sformatf("denominator %0d, expected %0d",
                                         rsp_result_denominator, want.denominator));
            end
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            end
         end
      end
   end

   initial begin : drive_stimulus
      logic [CMD_WIDTH-1:0] cmd;
      operand_type an, ad, bn, bd;
      fraction_type answer;
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_ADD;
      req_a_numerator <= '0;
      req_a_denominator <= '0;
      req_b_numerator <= '0;
      req_b_denominator <= '0;

      add_row(CMD_ADD, 1, 2, 1, 3, 1'b1, 5, 6, STAT_OK);
      add_row(CMD_SUB, 1, 2, 1, 3, 1'b1, 1, 6, STAT_OK);
      add_row(CMD_MUL, 3, 4, 5, 7, 1'b1, 15, 28, STAT_OK);
      add_row(CMD_DIV, 3, 4, 5, 7, 1'b1, 21, 20, STAT_OK);
      add_row(CMD_REDUCE, 6, 8, 0, 0, 1'b1, 3, 4, STAT_OK);
      add_row(CMD_ADD, 1, 0, 1, 3, 1'b1, 0, 0, STAT_ZERO_IN);
      add_row(CMD_MUL, 1, 3, 1, 0, 1'b1, 0, 0, STAT_ZERO_IN);
      add_row(CMD_DIV, 1, 1, 0, 0, 1'b1, 0, 0, STAT_ZERO_IN);
      add_row(CMD_SPARE_7, 3, 0, 1, 1, 1'b1, 0, 0, STAT_ZERO_IN);
      // Reduce ignores the second fraction, so a zero second denominator is no error.
      add_row(CMD_REDUCE, 5, -10, 0, 0, 1'b1, -1, 2, STAT_OK);
      add_row(CMD_DIV, 3, 4, 0, 5, 1'b1, 15, 0, STAT_ZERO_RESULT);
      add_row(CMD_REDUCE, 0, 7, 9, 9, 1'b1, 0, 1, STAT_OK);
      add_row(CMD_SPARE_5, 4, 6, 1, 1, 1'b1, 2, 3, STAT_OK);
      add_row(CMD_SPARE_6, -9, 3, 1, 1, 1'b1, -3, 1, STAT_OK);
      add_row(CMD_SPARE_7, 10, -4, 1, 1, 1'b1, -5, 2, STAT_OK);
      add_row(CMD_MUL, -32768, -32768, -32768, -32768, 1'b1, 1073741824, 1073741824, STAT_OK);
      add_row(CMD_REDUCE, -32768, -32768, 0, 0, 1'b1, 1, 1, STAT_OK);
      add_row(CMD_REDUCE, -32768, 1, 0, 0, 1'b1, -32768, 1, STAT_OK);
      add_row(CMD_ADD, 0, 1, 0, 1, 1'b1, 0, 1, STAT_OK);
      add_row(CMD_ADD, -1, -1, -1, -1, 1'b1, 2, 1, STAT_OK);
      add_row(CMD_MUL, 32767, 1, -32768, 1, 1'b0, 0, 0, STAT_OK);
      add_row(CMD_ADD, -32768, 32767, -32768, 32766, 1'b0, 0, 0, STAT_OK);
      add_row(CMD_SUB, 32767, -32768, -32768, 32767, 1'b0, 0, 0, STAT_OK);
      add_row(CMD_DIV, -32768, 1, -32768, 1, 1'b0, 0, 0, STAT_OK);
      add_row(CMD_DIV, 32767, 32767, 1, -1, 1'b0, 0, 0, STAT_OK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 61 : 0;
         if (phase == 0) begin
            foreach (directed_rows[i]) begin
               answer = directed_rows[i].typed ? directed_rows[i].answer :
                        predict_fraction(directed_rows[i].command, directed_rows[i].a_num,
                                         directed_rows[i].a_den, directed_rows[i].b_num,
                                         directed_rows[i].b_den);
               issue_fraction(directed_rows[i].command, directed_rows[i].a_num,
                              directed_rows[i].a_den, directed_rows[i].b_num,
                              directed_rows[i].b_den, answer);
            end
         end
         repeat (150) begin
            if ($urandom_range(99) < 90) cmd = CMD_WIDTH'($urandom_range(4));
            else cmd = CMD_WIDTH'($urandom_range(7, 5));
            an = random_field();
            ad = random_denominator();
            bn = random_field();
            bd = random_denominator();
            answer = predict_fraction(cmd, an, ad, bn, bd);
            issue_fraction(cmd, an, ad, bn, bd, answer);
         end
      end

      start <= 1'b0;
      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("fraction_arithmetic_unit test passed");
      end else begin
         $display("fraction_arithmetic_unit test failed");
      end
      $finish;
   end

endmodule
